// ===== design/ssht_pkg.sv =====
// Shared types and constants for the segment/sphere hit test block.
// No dependencies; imported by ssht_split_mul, segment_sphere_hit_test_unit and the bench.
`default_nettype none

package ssht_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_X      = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Y      = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CENTER_Z      = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPHERE_RADIUS = 8'd3;

    // Pipeline depth: diffs, products, sums, compares, partials, full products, result
    localparam int NUM_STAGES = 7;

    // Stage enables handed to the split multiplier
    typedef struct packed {
        logic pp_en;   // load partial products
        logic sum_en;  // load summed product
    } ssht_mul_ctrl_t;

    // Decision flags carried alongside the wide products
    typedef struct packed {
        logic degen;      // len2 == 0
        logic ll_le_r2;   // start point inside or on the sphere
        logic ll_ge_r2;   // start point outside or on the sphere
        logic ll_gt_r2;   // start point strictly outside
        logic b_ge_zero;  // b >= 0
        logic b_le_len2;  // b <= len2
        logic ee_le_r2;   // end point inside or on the sphere
        logic ee_ge_r2;   // end point outside or on the sphere
    } ssht_flags_t;

endpackage

`default_nettype wire

// ===== design/ssht_split_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on ssht_pkg (ssht_mul_ctrl_t).
`default_nettype none

module ssht_split_mul
    import ssht_pkg::*;
#(
    parameter int N = 34
) (
    input  wire logic             clk,
    input  wire ssht_mul_ctrl_t   ctrl,
    input  wire logic [N-1:0]     a,
    input  wire logic [N-1:0]     b,
    output logic      [2*N-1:0]   product
);

    localparam int H = (N + 1) / 2;

    logic [2*H-1:0] a_ext;
    logic [2*H-1:0] b_ext;
    logic [2*H-1:0] ll_reg;
    logic [2*H-1:0] lh_reg;
    logic [2*H-1:0] hl_reg;
    logic [2*H-1:0] hh_reg;
    logic [4*H-1:0] sum_next;
    logic [2*N-1:0] product_reg;

    assign a_ext = (2*H)'(a);
    assign b_ext = (2*H)'(b);

    // Stage one: partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.pp_en)
        begin
            ll_reg <= a_ext[H-1:0]   * b_ext[H-1:0];
            lh_reg <= a_ext[H-1:0]   * b_ext[2*H-1:H];
            hl_reg <= a_ext[2*H-1:H] * b_ext[H-1:0];
            hh_reg <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
        end
    end

    // Stage two: align and add
    assign sum_next = {hh_reg, ll_reg}
                    + (((4*H)'(lh_reg) + (4*H)'(hl_reg)) << H);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            product_reg <= sum_next[2*N-1:0];
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== design/segment_sphere_hit_test_unit.sv =====
// Top level of the segment/sphere hit test pipeline with its configuration registers.
// Depends on ssht_pkg and ssht_split_mul.
`default_nettype none

// Tests whether a segment from (start_x,start_y,start_z) to (end_x,end_y,end_z)
// crosses the surface of a sphere set by center_x/y/z and sphere_radius. The
// decision is exact: with d = end-start, L = center-start, len2 = d.d and
// b = L.d, a root (b +- sqrt(D))/len2 in [0,1] is found by squared integer
// compares only. A zero-length segment hits when its point is inside or on the
// sphere; a segment lying wholly inside the sphere is a miss. The block takes
// one segment per clock while the output side does not stall and returns one
// hit bit per segment, in order. The seven register stages are: coordinate
// differences, per-axis products, dot product sums, compares with the
// magnitude/difference set-up, then two stages for the wide b*b and
// len2*(|L|^2-r^2) products (each split into four half-width partial
// products), and the output register. Every stage holds its own valid bit
// and advances when the stage after it is empty or moving, so a stalled
// output only holds the stages that are full and bubbles are squeezed out.
// Configuration writes (cfg_index 0..3 for center_x, center_y, center_z,
// sphere_radius; other indexes are dropped) are always ready and take effect
// for segments transferred on the following cycle; write them only while no
// segment is in flight.
module segment_sphere_hit_test_unit
    import ssht_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write channel
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [COORD_WIDTH-1:0]      cfg_data,
    // segment input channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] start_z,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_z,
    // result channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             hit
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;        // coordinate difference
    localparam int PW  = 2 * W + 2;    // per-axis product
    localparam int SW  = 2 * W + 3;    // signed dot product sum
    localparam int MW  = 2 * W + 2;    // unsigned wide multiplier operand
    localparam int RW  = W - 1;        // radius
    localparam int R2W = 2 * RW;       // radius squared
    localparam int NS  = NUM_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [W-1:0]   center_x_reg;
    logic signed [W-1:0]   center_y_reg;
    logic signed [W-1:0]   center_z_reg;
    logic        [RW-1:0]  radius_reg;
    logic        [R2W-1:0] r2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:      center_x_reg <= cfg_data;
                CFG_CENTER_Y:      center_y_reg <= cfg_data;
                CFG_CENTER_Z:      center_z_reg <= cfg_data;
                CFG_SPHERE_RADIUS: radius_reg   <= cfg_data[RW-1:0];
                default:           ; // drop writes to unknown indexes
            endcase
        end
    end

    // Radius squared follows the radius register in the next cycle; it is
    // only read from the compare stage onwards, well after any write.
    always_ff @(posedge clk)
    begin
        r2_reg <= radius_reg * radius_reg;
    end

    // ------------------------------------------------------------------
    // Stage valids and enables
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    // A stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: differences d = e - s, l = c - s, g = c - e
    // ------------------------------------------------------------------
    logic signed [W-1:0]  s_pt [3];
    logic signed [W-1:0]  e_pt [3];
    logic signed [W-1:0]  c_pt [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] l_reg [3];
    logic signed [DW-1:0] g_reg [3];

    assign s_pt[0] = start_x;
    assign s_pt[1] = start_y;
    assign s_pt[2] = start_z;
    assign e_pt[0] = end_x;
    assign e_pt[1] = end_y;
    assign e_pt[2] = end_z;
    assign c_pt[0] = center_x_reg;
    assign c_pt[1] = center_y_reg;
    assign c_pt[2] = center_z_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i] <= DW'(e_pt[i]) - DW'(s_pt[i]);
                l_reg[i] <= DW'(c_pt[i]) - DW'(s_pt[i]);
                g_reg[i] <= DW'(c_pt[i]) - DW'(e_pt[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-axis products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] d_ext [3];
    logic signed [PW-1:0] l_ext [3];
    logic signed [PW-1:0] g_ext [3];
    logic signed [PW-1:0] dd_reg [3];
    logic signed [PW-1:0] ll_p_reg [3];
    logic signed [PW-1:0] gg_reg [3];
    logic signed [PW-1:0] ld_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_ext[i] = PW'(d_reg[i]);
            l_ext[i] = PW'(l_reg[i]);
            g_ext[i] = PW'(g_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i]   <= d_ext[i] * d_ext[i];
                ll_p_reg[i] <= l_ext[i] * l_ext[i];
                gg_reg[i]   <= g_ext[i] * g_ext[i];
                ld_reg[i]   <= l_ext[i] * d_ext[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot products len2, |L|^2, |G|^2 and b
    // ------------------------------------------------------------------
    logic signed [SW-1:0] len2_reg;
    logic signed [SW-1:0] ll_reg;
    logic signed [SW-1:0] ee_reg;
    logic signed [SW-1:0] b_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            len2_reg <= SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
            ll_reg   <= SW'(ll_p_reg[0]) + SW'(ll_p_reg[1]) + SW'(ll_p_reg[2]);
            ee_reg   <= SW'(gg_reg[0]) + SW'(gg_reg[1]) + SW'(gg_reg[2]);
            b_reg    <= SW'(ld_reg[0]) + SW'(ld_reg[1]) + SW'(ld_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compares, |b| and |L|^2 - r^2 for the discriminant test
    // ------------------------------------------------------------------
    logic signed [SW-1:0] r2_ext;
    logic signed [SW-1:0] b_neg;
    logic signed [SW-1:0] ll_minus_r2;
    ssht_flags_t          flags_next;
    ssht_flags_t          s3_flags_reg;
    ssht_flags_t          s4_flags_reg;
    ssht_flags_t          s5_flags_reg;
    logic [MW-1:0]        abs_b_reg;
    logic [MW-1:0]        dist_reg;

    assign r2_ext      = $signed(SW'(r2_reg));
    assign b_neg       = -b_reg;
    assign ll_minus_r2 = ll_reg - r2_ext;

    always_comb
    begin
        flags_next.degen     = (len2_reg == '0);
        flags_next.ll_le_r2  = (ll_reg <= r2_ext);
        flags_next.ll_ge_r2  = (ll_reg >= r2_ext);
        flags_next.ll_gt_r2  = (ll_reg > r2_ext);
        flags_next.b_ge_zero = !b_reg[SW-1];
        flags_next.b_le_len2 = (b_reg <= len2_reg);
        flags_next.ee_le_r2  = (ee_reg <= r2_ext);
        flags_next.ee_ge_r2  = (ee_reg >= r2_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_flags_reg <= flags_next;
            abs_b_reg    <= b_reg[SW-1] ? b_neg[MW-1:0] : b_reg[MW-1:0];
            // only consulted when the start point is outside, so positive
            dist_reg     <= ll_minus_r2[MW-1:0];
        end
    end

    // len2 travels one more stage to meet |L|^2 - r^2 at the multiplier
    logic [MW-1:0] len2_u;
    assign len2_u = len2_reg[MW-1:0];

    logic [MW-1:0] len2_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            len2_s3_reg <= len2_u;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 and 5: b*b and len2*(|L|^2 - r^2)
    // ------------------------------------------------------------------
    ssht_mul_ctrl_t mul_ctrl;
    logic [2*MW-1:0] bb;
    logic [2*MW-1:0] lm;

    assign mul_ctrl.pp_en  = en[4];
    assign mul_ctrl.sum_en = en[5];

    ssht_split_mul #(
        .N (MW)
    ) u_mul_bb (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .a       (abs_b_reg),
        .b       (abs_b_reg),
        .product (bb)
    );

    ssht_split_mul #(
        .N (MW)
    ) u_mul_lm (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .a       (len2_s3_reg),
        .b       (dist_reg),
        .product (lm)
    );

    // Flags advance with the multiplier stages
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_flags_reg <= s3_flags_reg;
        end
        if (en[5])
        begin
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final decision into the output register
    // ------------------------------------------------------------------
    logic hit_next;
    logic lo_ok;
    logic hi_ok;
    logic hit_reg;

    always_comb
    begin
        // smaller root b - sqrt(D) within [0, len2]
        lo_ok = s5_flags_reg.b_ge_zero && s5_flags_reg.ll_ge_r2
             && (s5_flags_reg.b_le_len2 || s5_flags_reg.ee_le_r2);
        // larger root b + sqrt(D) within [0, len2]
        hi_ok = (s5_flags_reg.b_ge_zero || s5_flags_reg.ll_le_r2)
             && s5_flags_reg.b_le_len2 && s5_flags_reg.ee_ge_r2;
        if (s5_flags_reg.degen)
        begin
            hit_next = s5_flags_reg.ll_le_r2;
        end
        else if (s5_flags_reg.ll_gt_r2 && (bb < lm))
        begin
            // negative discriminant: the line misses the sphere
            hit_next = 1'b0;
        end
        else
        begin
            hit_next = lo_ok || hi_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NS-1] |-> in_ready)
        else $error("input not ready although the output register is empty");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("input transfer did not fill the first stage");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && valid_reg[NS-2] |=> valid_reg[NS-2] && out_valid)
        else $error("stalled pipeline dropped an item");

    a_degenerate_result: assert property (@(posedge clk) disable iff (!rst_n)
        en[NS-1] && valid_reg[NS-2] && s5_flags_reg.degen
        |=> hit == $past(s5_flags_reg.ll_le_r2))
        else $error("zero-length segment result differs from the point test");

endmodule

`default_nettype wire

// ===== verif/segment_sphere_hit_test_unit_test.sv =====
// Self-checking bench for segment_sphere_hit_test_unit: exact segment/sphere predictor,
// queue-fed segment driver, stalling result monitor. Depends on ssht_pkg and the design.
`default_nettype none

module segment_sphere_hit_test_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssht_pkg::*;

    localparam int CW = 16;               // coordinate width
    localparam int RW = CW - 1;           // radius width
    localparam int PERIOD = 4;
    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD = 300;       // receiver hold-off, far beyond pipeline depth
    localparam int PHASE_ITEMS = 250;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [127:0] wide_t;  // ample headroom for b*b and len2*(|L|^2-r^2)

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } segment_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0]              cfg_data = '0;

    logic   in_valid = 1'b0;
    logic   in_ready;
    coord_t start_x = '0;
    coord_t start_y = '0;
    coord_t start_z = '0;
    coord_t end_x = '0;
    coord_t end_y = '0;
    coord_t end_z = '0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;

    always #(PERIOD / 2) clk = ~clk;

    segment_sphere_hit_test_unit #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .start_x  (start_x),
        .start_y  (start_y),
        .start_z  (start_z),
        .end_x    (end_x),
        .end_y    (end_y),
        .end_z    (end_z),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit      (hit)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the sphere registers, held in step with each cfg transfer
    // ------------------------------------------------------------------
    coord_t          center_x_cfg = '0;
    coord_t          center_y_cfg = '0;
    coord_t          center_z_cfg = '0;
    logic [RW-1:0]   radius_cfg = '0;

    segment_t pending_segments[$];   // segments waiting to be offered
    logic     expected_hits[$];      // hit bits owed by the block, oldest first
    segment_t segment_on_bus;

    bit          idle_mode = 1'b1;   // clear for a stretch with no gaps on either side
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;

    int unsigned error_count = 0;
    int unsigned segments_sent = 0;
    int unsigned results_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned config_writes = 0;
    int unsigned sphere_settings = 0;
    logic        wanted_hit;

    // ------------------------------------------------------------------
    // Predictor: exact integer line/sphere root test, no square root
    // ------------------------------------------------------------------
    function automatic wide_t dot3(longint a0, longint a1, longint a2,
                                   longint b0, longint b1, longint b2);
        return wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1)
             + wide_t'(a2) * wide_t'(b2);
    endfunction

    function automatic logic predict_hit(segment_t seg);
        longint dx, dy, dz, lx, ly, lz, gx, gy, gz, r;
        wide_t  len2, ll, ee, b, r2;
        logic   lo_ok, hi_ok;
        dx = longint'($signed(seg.ex)) - longint'($signed(seg.sx));
        dy = longint'($signed(seg.ey)) - longint'($signed(seg.sy));
        dz = longint'($signed(seg.ez)) - longint'($signed(seg.sz));
        lx = longint'(center_x_cfg) - longint'($signed(seg.sx));
        ly = longint'(center_y_cfg) - longint'($signed(seg.sy));
        lz = longint'(center_z_cfg) - longint'($signed(seg.sz));
        gx = longint'(center_x_cfg) - longint'($signed(seg.ex));
        gy = longint'(center_y_cfg) - longint'($signed(seg.ey));
        gz = longint'(center_z_cfg) - longint'($signed(seg.ez));
        r = longint'(radius_cfg);
        r2 = wide_t'(r) * wide_t'(r);
        len2 = dot3(dx, dy, dz, dx, dy, dz);
        ll = dot3(lx, ly, lz, lx, ly, lz);
        // a zero-length segment is a point: inside or on the surface counts
        if (len2 == 0)
            return ll <= r2;
        b = dot3(lx, ly, lz, dx, dy, dz);
        ee = dot3(gx, gy, gz, gx, gy, gz);
        // start outside and negative discriminant: the line never meets the sphere
        if (ll > r2 && b * b < len2 * (ll - r2))
            return 1'b0;
        // entry root (b - sqrt D) and exit root (b + sqrt D) against [0, len2]
        lo_ok = b >= 0 && ll >= r2 && (b <= len2 || ee <= r2);
        hi_ok = (b >= 0 || ll <= r2) && b <= len2 && ee >= r2;
        return lo_ok || hi_ok;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_segment(int sx, int sy, int sz, int ex, int ey, int ez);
        segment_t seg;
        seg.sx = coord_t'(sx);
        seg.sy = coord_t'(sy);
        seg.sz = coord_t'(sz);
        seg.ex = coord_t'(ex);
        seg.ey = coord_t'(ey);
        seg.ez = coord_t'(ez);
        pending_segments.push_back(seg);
    endfunction

    // Offset a coordinate by a random amount in [-spread, spread]; wrap at the port width
    function automatic coord_t jitter(coord_t c, int spread);
        return coord_t'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Mostly geometry close to the current sphere, with some full-range noise
    function automatic segment_t random_segment();
        segment_t    seg;
        coord_t      cen[3];
        coord_t      p[3];
        coord_t      q[3];
        int          r, spread, a, o, k, side;
        int unsigned kind;
        cen[0] = center_x_cfg;
        cen[1] = center_y_cfg;
        cen[2] = center_z_cfg;
        r = int'(radius_cfg);
        spread = r + r / 2 + 8;
        kind = $urandom_range(0, 99);
        for (k = 0; k < 3; k++)
        begin
            p[k] = jitter(cen[k], spread);
            q[k] = jitter(cen[k], spread);
        end
        if (kind < 25)
        begin
            // full-range noise: every port bit toggles
            for (k = 0; k < 3; k++)
            begin
                p[k] = coord_t'($urandom);
                q[k] = coord_t'($urandom);
            end
        end
        else if (kind < 65)
        begin
            // both ends near the sphere: keep the jittered points
        end
        else if (kind < 75)
        begin
            // zero-length segment near the sphere
            q = p;
        end
        else if (kind < 85)
        begin
            // both ends well inside: per-axis offset at most r/2
            for (k = 0; k < 3; k++)
            begin
                p[k] = jitter(cen[k], r / 2);
                q[k] = jitter(cen[k], r / 2);
            end
        end
        else if (kind < 93)
        begin
            // tangent line: one axis offset by exactly r, run along a second axis
            a = $urandom_range(0, 2);
            o = (a + 1) % 3;
            side = $urandom_range(0, 1) ? r : -r;
            p = cen;
            q = cen;
            p[o] = coord_t'(int'(cen[o]) + side);
            q[o] = p[o];
            p[a] = jitter(cen[a], 2 * r + 2);
            q[a] = jitter(cen[a], 2 * r + 2);
        end
        else
        begin
            // start exactly on the surface
            a = $urandom_range(0, 2);
            side = $urandom_range(0, 1) ? r : -r;
            p = cen;
            p[a] = coord_t'(int'(cen[a]) + side);
        end
        seg.sx = p[0];
        seg.sy = p[1];
        seg.sz = p[2];
        seg.ex = q[0];
        seg.ey = q[1];
        seg.ez = q[2];
        return seg;
    endfunction

    // One register transfer on the cfg channel; update the shadow copy on acceptance
    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [CW-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_CENTER_X:      center_x_cfg = data;
            CFG_CENTER_Y:      center_y_cfg = data;
            CFG_CENTER_Z:      center_z_cfg = data;
            CFG_SPHERE_RADIUS: radius_cfg = data[RW-1:0];   // top bit dropped by the block
            default:           ;                            // unknown index: no effect
        endcase
        config_writes++;
    endtask

    task automatic set_sphere(input int cx, input int cy, input int cz, input int rdata);
        write_register(CFG_CENTER_X, CW'(cx));
        write_register(CFG_CENTER_Y, CW'(cy));
        write_register(CFG_CENTER_Z, CW'(cz));
        write_register(CFG_SPHERE_RADIUS, CW'(rdata));
        sphere_settings++;
    endtask

    // Hold until every queued segment has been transferred and answered, then let
    // the pipeline settle before the registers are touched again
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_segments.size() != 0 || in_valid || expected_hits.size() != 0);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) pending_segments.push_back(random_segment());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued segments, hold payload until transfer, then
    // predict the owed hit bit from the accepted segment
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_hits.push_back(predict_hit(segment_on_bus));
                segments_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_segments.size() > 0)
                begin
                    segment_on_bus = pending_segments.pop_front();
                    start_x <= segment_on_bus.sx;
                    start_y <= segment_on_bus.sy;
                    start_z <= segment_on_bus.sz;
                    end_x <= segment_on_bus.ex;
                    end_y <= segment_on_bus.ey;
                    end_z <= segment_on_bus.ez;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest owed bit, and
    // drive out_ready with random stalls plus the occasional long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    $error("hit transfer with no segment outstanding: actual %0b", hit);
                    error_count++;
                end
                else
                begin
                    wanted_hit = expected_hits.pop_front();
                    if (hit !== wanted_hit)
                    begin
                        $error("hit mismatch on result %0d: expected %0b, actual %0b",
                               results_seen, wanted_hit, hit);
                        error_count++;
                    end
                    if (wanted_hit)
                        hits_seen++;
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served++;
                recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then random phases over several spheres
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still at reset: sphere of radius 0 at the origin
        queue_segment(0, 0, 0, 0, 0, 0);              // point on the zero sphere
        queue_segment(-5, 0, 0, 5, 0, 0);             // passes through the point
        queue_segment(1, 0, 0, 1, 0, 0);              // point just off it
        wait_drained();

        set_sphere(100, -200, 300, 50);
        queue_segment(100, -200, 300, 100, -200, 300);    // point at the centre
        queue_segment(150, -200, 300, 150, -200, 300);    // point on the surface
        queue_segment(151, -200, 300, 151, -200, 300);    // point just outside
        queue_segment(0, -200, 300, 200, -200, 300);      // straight through
        queue_segment(90, -200, 300, 110, -195, 305);     // wholly inside
        queue_segment(0, -150, 300, 200, -150, 300);      // tangent, contact on segment
        queue_segment(150, -150, 300, 300, -150, 300);    // tangent, contact beyond start
        queue_segment(0, -100, 300, 200, -100, 300);      // line misses sphere
        queue_segment(100, -200, 300, 100, -200, 500);    // inside to outside
        queue_segment(100, -200, 0, 100, -200, 310);      // outside to inside
        queue_segment(100, -200, 100, 100, -200, 250);    // ends on the surface
        queue_segment(100, -200, 400, 100, -200, 500);    // heading away
        queue_segment(100, -200, 350, 100, -200, 400);    // starts on the surface
        queue_segment(-32768, -32768, -32768, 32767, 32767, 32767);
        queue_segment(32767, 32767, 32767, -32768, -32768, -32768);
        queue_segment(-32768, 32767, -32768, -32768, 32767, -32768);
        wait_drained();

        // Writes to unknown indexes must leave the sphere alone
        write_register(CFG_SPHERE_RADIUS + 8'd1, 16'h1234);
        write_register({CFG_INDEX_WIDTH{1'b1}}, 16'hFFFF);

        // Modest sphere near the origin; fill the pipeline against a long hold-off
        set_sphere(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
                   int'($urandom_range(0, 4000)) - 2000, $urandom_range(1, 3000));
        hold_requests++;
        run_random(PHASE_ITEMS);

        // Lowest corner, largest radius written with the excess top bit set; no idling
        idle_mode = 1'b0;
        set_sphere(-32768, -32768, -32768, 16'hFFFF);
        run_random(PHASE_ITEMS);
        idle_mode = 1'b1;

        // Highest corner, zero radius
        set_sphere(32767, 32767, 32767, 0);
        run_random(PHASE_ITEMS);

        // Anywhere, any radius
        set_sphere($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS);

        // Small sphere, so tangents and surface points sit on a coarse grid
        set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 50));
        hold_requests++;
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (2 * NUM_STAGES) @(posedge clk);
        $display("Summary: %0d segments over %0d sphere settings, %0d register writes.",
                 segments_sent, sphere_settings, config_writes);
        $display("Summary: %0d results checked, %0d hits, %0d errors.",
                 results_seen, hits_seen, error_count);
        if (error_count == 0)
            $display("segment_sphere_hit_test_unit verification clean");
        else
            $display("segment_sphere_hit_test_unit verification failed");
        $finish;
    end

    // Watchdog: the slowest legal run finishes far inside this
    initial
    begin
        #2_000_000;
        $display("segment_sphere_hit_test_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
